/* src/prts_pkg.sv */
// Shared types and constants for the priority round-robin task scheduler.
package prts_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CntW     = SlotW + 1;
  localparam int TicksW   = 32;
  localparam int PrioW    = 8;
  localparam int OpW      = 3;
  localparam int ErrW     = 2;
  localparam int InDataW  = 48;
  localparam int OutDataW = 16;

  localparam logic [PrioW-1:0] IdlePrio = 8'd255;

  // Event codes
  localparam logic [OpW-1:0] OpCreate    = 3'd0;
  localparam logic [OpW-1:0] OpActivate  = 3'd1;
  localparam logic [OpW-1:0] OpTerminate = 3'd2;
  localparam logic [OpW-1:0] OpWait      = 3'd3;
  localparam logic [OpW-1:0] OpTick      = 3'd4;
  localparam logic [OpW-1:0] OpStart     = 3'd5;

  // Task run states
  localparam logic [1:0] StSusp  = 2'd0;
  localparam logic [1:0] StWait  = 2'd1;
  localparam logic [1:0] StReady = 2'd2;
  localparam logic [1:0] StRun   = 2'd3;

  // Error codes
  localparam logic [ErrW-1:0] ErrNone    = 2'd0;
  localparam logic [ErrW-1:0] ErrFull    = 2'd1;
  localparam logic [ErrW-1:0] ErrBadSlot = 2'd2;

  // Event class decided at the front
  typedef enum logic [1:0] {
    KindCreate = 2'd0,
    KindTask   = 2'd1,
    KindTick   = 2'd2,
    KindOther  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [OpW-1:0]    op;
    logic [SlotW-1:0]  task_id;
    logic [PrioW-1:0]  task_priority;
    logic [TicksW-1:0] wait_ticks;
  } item_t;

endpackage

/* src/priority_round_robin_task_scheduler.sv */
// Top level of the priority round-robin task scheduler.
// Create, bad-slot and unknown events go straight to the result; start runs the minimum
// and fill scans, other task events may add a dispatch step, and a tick first scans the
// delays, one slot per cycle over the slots in use. One event is worked on at a time;
// a two-item input queue keeps accepting while a result waits. Asynchronous active-low
// reset: only the idle task exists, scheduler not started, ready queue empty.
module priority_round_robin_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op, task_id, task_priority, wait_ticks, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // current_task, switched, assigned_id, ready_count, error
);
  import prts_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  prts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  prts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* src/prts_front.sv */
// Front end: accepts events, classifies them and queues them for the engine.
module prts_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [prts_pkg::InDataW-1:0] in_data_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output prts_pkg::item_t        q_item_o
);
  import prts_pkg::*;

  item_t      queue_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls;
  logic       push, pop;

  // Unpack and classify the incoming item
  always_comb begin
    cls.op            = in_data_i[2:0];
    cls.task_id       = in_data_i[6:3];
    cls.task_priority = in_data_i[14:7];
    cls.wait_ticks    = in_data_i[46:15];
    case (cls.op)
      OpCreate:                           cls.kind = KindCreate;
      OpActivate, OpTerminate, OpWait:    cls.kind = KindTask;
      OpTick:                             cls.kind = KindTick;
      default:                            cls.kind = KindOther;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = queue_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= cls;
    end
  end

endmodule

/* src/prts_back.sv */
// Back end: task table, ready queue and the scan sequencer that runs each event.
module prts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  prts_pkg::item_t               q_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prts_pkg::OutDataW-1:0] out_data_o
);
  import prts_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] STick = 3'd1;
  localparam logic [2:0] SMin  = 3'd2;
  localparam logic [2:0] SFill = 3'd3;
  localparam logic [2:0] SDec  = 3'd4;
  localparam logic [2:0] SOut  = 3'd5;

  logic [2:0]        st_q;
  logic [PrioW-1:0]  prio_q [MaxTasks];
  logic [1:0]        rs_q   [MaxTasks];
  logic              blk_q  [MaxTasks];
  logic [TicksW-1:0] dc_q   [MaxTasks];
  logic [SlotW-1:0]  fifo_q [MaxTasks];
  logic [SlotW-1:0]  head_q, run_q, idx_q, assigned_q;
  logic [CntW-1:0]   fill_q, used_q;
  logic [PrioW:0]    best_q;
  logic              started_q, woke_q, dodec_q, sw_q;
  logic [ErrW-1:0]   err_q;

  logic [SlotW-1:0]  cur, nxt, tail;
  logic              last, hit, expire, cand, rot;
  logic [TicksW-1:0] dcm1;
  logic              dc_we, fifo_we;
  logic [SlotW-1:0]  dc_wa, fifo_wa, fifo_wd;
  logic [TicksW-1:0] dc_wd;

  // Per-slot scan terms
  always_comb begin
    cur    = run_q;
    nxt    = fifo_q[head_q];
    // ring index wraps naturally since the depth is a power of two
    tail   = head_q + fill_q[SlotW-1:0];
    last   = ({1'b0, idx_q} == (used_q - CntW'(1)));
    hit    = (rs_q[idx_q] == StSusp) && blk_q[idx_q];
    dcm1   = dc_q[idx_q] - TicksW'(1);
    expire = hit && (dcm1 == '0);
    cand   = (rs_q[idx_q] != StSusp);
    rot    = (prio_q[cur] == prio_q[nxt]) && ((cur == nxt) || (rs_q[cur] != StSusp));
  end

  // Write ports of the delay and ready stores
  always_comb begin
    dc_we   = 1'b0;
    dc_wa   = idx_q;
    dc_wd   = dcm1;
    fifo_we = 1'b0;
    fifo_wa = tail;
    fifo_wd = cur;
    case (st_q)
      SIdle: begin
        if (q_valid_i && q_item_i.op == OpWait &&
            {1'b0, q_item_i.task_id} < used_q) begin
          dc_we = 1'b1;
          dc_wa = q_item_i.task_id;
          dc_wd = q_item_i.wait_ticks;
        end
      end
      STick: dc_we = hit;
      SFill: begin
        fifo_we = cand && ({1'b0, prio_q[idx_q]} == best_q);
        fifo_wa = fill_q[SlotW-1:0];
        fifo_wd = idx_q;
      end
      SDec: begin
        if (fill_q == '0) fifo_we = (rs_q[cur] != StSusp);
        else              fifo_we = rot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dc_we)   dc_q[dc_wa]     <= dc_wd;
    if (fifo_we) fifo_q[fifo_wa] <= fifo_wd;
  end

  // Sequence each event through its scans
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      for (int i = 0; i < MaxTasks; i++) begin
        prio_q[i] <= '0;
        rs_q[i]   <= StSusp;
        blk_q[i]  <= 1'b0;
      end
      prio_q[0]  <= IdlePrio;
      head_q     <= '0;
      fill_q     <= '0;
      run_q      <= '0;
      used_q     <= CntW'(1);
      started_q  <= 1'b0;
      idx_q      <= '0;
      best_q     <= '0;
      woke_q     <= 1'b0;
      dodec_q    <= 1'b0;
      sw_q       <= 1'b0;
      err_q      <= ErrNone;
      assigned_q <= '0;
    end else begin
      case (st_q)
        SIdle: begin
          if (q_valid_i) begin
            sw_q       <= 1'b0;
            err_q      <= ErrNone;
            assigned_q <= '0;
            idx_q      <= '0;
            best_q     <= {1'b1, {PrioW{1'b0}}};
            woke_q     <= 1'b0;
            case (q_item_i.kind)
              KindCreate: begin
                if (used_q == CntW'(MaxTasks)) begin
                  err_q <= ErrFull;
                end else begin
                  prio_q[used_q[SlotW-1:0]] <= q_item_i.task_priority;
                  rs_q[used_q[SlotW-1:0]]   <= StSusp;
                  blk_q[used_q[SlotW-1:0]]  <= 1'b0;
                  assigned_q                <= used_q[SlotW-1:0];
                  used_q                    <= used_q + CntW'(1);
                end
                st_q <= SOut;
              end
              KindTask: begin
                if ({1'b0, q_item_i.task_id} >= used_q) begin
                  err_q <= ErrBadSlot;
                  st_q  <= SOut;
                end else begin
                  case (q_item_i.op)
                    OpActivate: rs_q[q_item_i.task_id] <= StWait;
                    OpWait: begin
                      rs_q[q_item_i.task_id]  <= StSusp;
                      blk_q[q_item_i.task_id] <= 1'b1;
                    end
                    default: rs_q[q_item_i.task_id] <= StSusp;
                  endcase
                  dodec_q <= started_q && (run_q != '0);
                  st_q    <= SMin;
                end
              end
              KindTick: begin
                dodec_q <= started_q;
                st_q    <= STick;
              end
              default: begin
                if (q_item_i.op == OpStart) begin
                  started_q <= 1'b1;
                  run_q     <= '0;
                  rs_q[0]   <= StWait;
                  dodec_q   <= 1'b0;
                  st_q      <= SMin;
                end else begin
                  st_q <= SOut;
                end
              end
            endcase
          end
        end
        STick: begin
          // count delays down, wake expired tasks
          if (expire) begin
            blk_q[idx_q] <= 1'b0;
            rs_q[idx_q]  <= StWait;
            woke_q       <= 1'b1;
          end
          if (last) begin
            idx_q <= '0;
            if (woke_q || expire) st_q <= SMin;
            else if (dodec_q)     st_q <= SDec;
            else                  st_q <= SOut;
          end else begin
            idx_q <= idx_q + SlotW'(1);
          end
        end
        SMin: begin
          // find best priority among live tasks
          if (cand && {1'b0, prio_q[idx_q]} < best_q) best_q <= {1'b0, prio_q[idx_q]};
          if (last) begin
            idx_q  <= '0;
            fill_q <= '0;
            head_q <= '0;
            st_q   <= SFill;
          end else begin
            idx_q <= idx_q + SlotW'(1);
          end
        end
        SFill: begin
          // queue every live task at the best priority
          if (cand && ({1'b0, prio_q[idx_q]} == best_q)) begin
            rs_q[idx_q] <= StReady;
            fill_q      <= fill_q + CntW'(1);
          end
          if (last) st_q <= dodec_q ? SDec : SOut;
          else      idx_q <= idx_q + SlotW'(1);
        end
        SDec: begin
          sw_q <= 1'b1;
          if (fill_q == '0) begin
            if (rs_q[cur] != StSusp) begin
              rs_q[cur] <= StRun;
              fill_q    <= CntW'(1);
            end
          end else begin
            // pop head, rotate an equal-priority current task to the tail
            head_q    <= head_q + SlotW'(1);
            rs_q[nxt] <= StRun;
            if (rot && cur != nxt) rs_q[cur] <= StReady;
            if (!rot) fill_q <= fill_q - CntW'(1);
            run_q <= nxt;
          end
          st_q <= SOut;
        end
        SOut: begin
          if (out_ready_i) st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign q_ready_o   = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);
  assign out_data_o  = {err_q, fill_q, assigned_q, sw_q, run_q};

endmodule

/* src/prts_checker.sv */
// Port-level checks for the task scheduler, bound to the top level.
module prts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import prts_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Ready count never exceeds the table depth
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:9] <= 5'd16)
    else $error("ready count out of range");

  // Error events make no switch and assign no slot
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:14] != ErrNone |->
      !m_axis_tdata[4] && m_axis_tdata[8:5] == 4'd0)
    else $error("error result with side effects");

  // Only the defined error codes are produced
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:14] == ErrNone || m_axis_tdata[15:14] == ErrFull ||
      m_axis_tdata[15:14] == ErrBadSlot)
    else $error("undefined error code");

endmodule

bind priority_round_robin_task_scheduler prts_checker u_prts_checker (.*);
